/* hdl/ptc_pkg.sv */
// shared types and constants for the postfix tautology checker
`default_nettype none

package ptc_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int VEC_W       = 16;

    localparam logic [VEC_W-1:0] VEC_P    = 16'hFF00;
    localparam logic [VEC_W-1:0] VEC_Q    = 16'hF0F0;
    localparam logic [VEC_W-1:0] VEC_R    = 16'hCCCC;
    localparam logic [VEC_W-1:0] VEC_S    = 16'hAAAA;
    localparam logic [VEC_W-1:0] VEC_NONE = 16'h0000;
    localparam logic [VEC_W-1:0] VEC_ALL  = 16'hFFFF;

    localparam logic [7:0] TOK_P     = 8'h70;  // p
    localparam logic [7:0] TOK_Q     = 8'h71;  // q
    localparam logic [7:0] TOK_R     = 8'h72;  // r
    localparam logic [7:0] TOK_S     = 8'h73;  // s
    localparam logic [7:0] TOK_FALSE = 8'h30;  // 0
    localparam logic [7:0] TOK_TRUE  = 8'h31;  // 1
    localparam logic [7:0] TOK_NOT   = 8'h21;  // !
    localparam logic [7:0] TOK_IMPL  = 8'h3E;  // >
    localparam logic [7:0] TOK_AND   = 8'h5E;  // ^
    localparam logic [7:0] TOK_OR    = 8'h76;  // v
    localparam logic [7:0] TOK_EQU   = 8'h3D;  // =

    typedef enum logic [1:0] {
        VERDICT_TAUT       = 2'd0,
        VERDICT_CONTRA     = 2'd1,
        VERDICT_CONTINGENT = 2'd2
    } verdict_t;

    typedef struct packed {
        verdict_t         verdict;
        logic [VEC_W-1:0] vec;
        logic             error;
    } result_t;

endpackage

`default_nettype wire

/* hdl/postfix_tautology_checker_top.sv */
// Postfix tautology checker: takes one expression character per request and
// keeps a stack of 16-bit truth vectors covering all assignments of p, q, r
// and s. One character is taken every cycle while no final character is
// stalled; its stack update is done combinationally from the registered
// input, so the operand stack registers and their one-step update set the
// rate. The result of an expression is computed from its last character in
// the input register and held in an output register. Non-final characters
// keep flowing while a result waits; a final character is held in the input
// register, and stalls further requests, until the output register is free.
`default_nettype none

module postfix_tautology_checker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  token,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       verdict,
    output logic [15:0]      truth_vector,
    output logic             error
);
    import ptc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] token_reg;
    logic       last_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_next;
    logic       out_free;
    logic       advance;

    assign out_free = !out_valid_reg || out_ready;
    // a non-final character never needs the output slot
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign in_ready = !in_valid_reg || advance;

    ptc_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .token  (token_reg),
        .last   (last_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance && last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            token_reg <= token;
            last_reg  <= last;
        end
        if (advance && last_reg) begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = result_reg.verdict;
    assign truth_vector = result_reg.vec;
    assign error        = result_reg.error;

endmodule

`default_nettype wire

/* hdl/ptc_eval.sv */
// operand stack of truth vectors and per-character evaluation
`default_nettype none

module ptc_eval (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       token,
    input  wire logic             last,
    output ptc_pkg::result_t      result
);
    import ptc_pkg::*;

    // top of stack lives at index 0, so every read is at a fixed place
    logic [VEC_W-1:0]   stack_reg  [STACK_DEPTH];
    logic [VEC_W-1:0]   stack_next [STACK_DEPTH];
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               err_reg;
    logic               err_next;
    logic [VEC_W-1:0]   push_vec;
    logic [VEC_W-1:0]   op_vec;
    logic [VEC_W-1:0]   final_vec;
    logic               is_push;
    logic               is_binary;
    logic               is_not;

    always_comb
    begin
        push_vec  = VEC_NONE;
        op_vec    = VEC_NONE;
        is_push   = 1'b0;
        is_binary = 1'b0;
        is_not    = 1'b0;
        unique case (token) inside
            TOK_P:     begin is_push = 1'b1; push_vec = VEC_P; end
            TOK_Q:     begin is_push = 1'b1; push_vec = VEC_Q; end
            TOK_R:     begin is_push = 1'b1; push_vec = VEC_R; end
            TOK_S:     begin is_push = 1'b1; push_vec = VEC_S; end
            TOK_FALSE: begin is_push = 1'b1; push_vec = VEC_NONE; end
            TOK_TRUE:  begin is_push = 1'b1; push_vec = VEC_ALL; end
            TOK_NOT:   is_not = 1'b1;
            TOK_IMPL:  begin is_binary = 1'b1; op_vec = ~stack_reg[1] | stack_reg[0]; end
            TOK_AND:   begin is_binary = 1'b1; op_vec = stack_reg[1] & stack_reg[0]; end
            TOK_OR:    begin is_binary = 1'b1; op_vec = stack_reg[1] | stack_reg[0]; end
            TOK_EQU:   begin is_binary = 1'b1; op_vec = ~(stack_reg[1] ^ stack_reg[0]); end
            default:   ;
        endcase
    end

    always_comb
    begin
        stack_next = stack_reg;
        depth_next = depth_reg;
        err_next   = err_reg;
        if (is_push) begin
            if (depth_reg == DEPTH_W'(STACK_DEPTH)) begin
                err_next = 1'b1;
            end else begin
                stack_next[0] = push_vec;
                for (int i = 1; i < STACK_DEPTH; i++) begin
                    stack_next[i] = stack_reg[i-1];
                end
                depth_next = depth_reg + DEPTH_W'(1);
            end
        end else if (is_not) begin
            if (depth_reg == '0) begin
                err_next = 1'b1;
            end else begin
                stack_next[0] = ~stack_reg[0];
            end
        end else if (is_binary) begin
            if (depth_reg < DEPTH_W'(2)) begin
                err_next = 1'b1;
            end else begin
                // pop two, push one: shift up by one under the new top
                stack_next[0] = op_vec;
                for (int i = 1; i < STACK_DEPTH - 1; i++) begin
                    stack_next[i] = stack_reg[i+1];
                end
                depth_next = depth_reg - DEPTH_W'(1);
            end
        end
    end

    always_comb
    begin
        final_vec    = (depth_next == '0) ? VEC_NONE : stack_next[0];
        result.vec   = final_vec;
        result.error = err_next || (depth_next != DEPTH_W'(1));
        if (final_vec == VEC_ALL) begin
            result.verdict = VERDICT_TAUT;
        end else if (final_vec == VEC_NONE) begin
            result.verdict = VERDICT_CONTRA;
        end else begin
            result.verdict = VERDICT_CONTINGENT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            depth_reg <= '0;
            err_reg   <= 1'b0;
        end else if (step) begin
            if (last) begin
                depth_reg <= '0;
                err_reg   <= 1'b0;
            end else begin
                depth_reg <= depth_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            stack_reg <= stack_next;
        end
    end

endmodule

`default_nettype wire
